>>> rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// shared constants, codes and types of the pixel point transform core
// ----------------------------------------------------------------------------
package ppt_pkg;

  // channel format
  localparam int CH_FRAC = 15;
  localparam int CH_W    = 16;
  localparam logic [CH_W-1:0] CH_ONE = CH_W'(1 << CH_FRAC);
  localparam int LANES   = 3;

  // fixed-point log2, Q5.24
  localparam int LG_FRAC = 24;
  localparam int LG_W    = 29;
  localparam int LG_LAT  = LG_FRAC + 1;

  // fraction divider
  localparam int NUM_W    = 45;
  localparam int DEN_W    = 50;
  localparam int DIV_LAT  = CH_FRAC + 1;

  // inverse log search, one result bit per step
  localparam int SRCH_W    = CH_FRAC;
  localparam int SRCH_LAT  = 1 + SRCH_W * (LG_LAT + 1);
  localparam int TGT_W     = 28;

  // input register, log of m*v, two arithmetic stages, search, result register
  localparam int LANE_LAT = 4 + LG_LAT + SRCH_LAT;

  // opcodes
  localparam logic [1:0] OP_NEG  = 2'd0;
  localparam logic [1:0] OP_LOG  = 2'd1;
  localparam logic [1:0] OP_POW  = 2'd2;

  // lane result source
  localparam logic [1:0] SEL_FIX  = 2'd0;
  localparam logic [1:0] SEL_DIV  = 2'd1;
  localparam logic [1:0] SEL_SRCH = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_MAX_INTENSITY  = 3'd0;
  localparam logic [2:0] CFG_LOG_GAIN       = 3'd1;
  localparam logic [2:0] CFG_LOG_RADIX      = 3'd2;
  localparam logic [2:0] CFG_GAMMA_GAIN     = 3'd3;
  localparam logic [2:0] CFG_GAMMA_EXPONENT = 3'd4;

  // settings seen by every lane; the user must keep them stable while pixels are in flight (not enforced)
  typedef struct packed {
    logic [15:0]        meff;
    logic [15:0]        log_gain;
    logic [15:0]        gamma_gain;
    logic [15:0]        gamma_exp;
    logic               lg_ok;
    logic signed [31:0] egc;
    logic [DEN_W-1:0]   den_log;
    logic [28:0]        den_g;
  } lane_cfg_t;

endpackage

>>> rtl/ppt_lg.sv
// ----------------------------------------------------------------------------
// ppt_lg
// pipelined base-2 log of a 32-bit integer, Q5.24, one fraction bit a stage
// ----------------------------------------------------------------------------
module ppt_lg (
  input  logic                      clk,
  input  logic                      en,
  input  logic [31:0]               x,
  output logic [ppt_pkg::LG_W-1:0]  r
);

  logic [4:0]               n;
  logic [31:0]              m0;
  logic [31:0]              m_st [ppt_pkg::LG_LAT];
  logic [ppt_pkg::LG_W-1:0] r_st [ppt_pkg::LG_LAT];
  logic [63:0]              sq   [1:ppt_pkg::LG_LAT-1];

  // leading one position and normalized mantissa
  always_comb begin
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = 5'(i);
    end
    m0 = x << (5'd31 - n);
  end

  always_comb begin
    for (int k = 1; k < ppt_pkg::LG_LAT; k++) sq[k] = m_st[k-1] * m_st[k-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_st[0] <= m0;
      r_st[0] <= {n, {ppt_pkg::LG_FRAC{1'b0}}};
      for (int k = 1; k < ppt_pkg::LG_LAT; k++) begin
        // square reached 2.0: bit set, mantissa halved
        if (sq[k][63]) begin
          m_st[k] <= sq[k][63:32];
          r_st[k] <= r_st[k-1] | (ppt_pkg::LG_W'(1) << (ppt_pkg::LG_FRAC - k));
        end else begin
          m_st[k] <= sq[k][62:31];
          r_st[k] <= r_st[k-1];
        end
      end
    end
  end

  assign r = r_st[ppt_pkg::LG_LAT-1];

endmodule

>>> rtl/ppt_div.sv
// ----------------------------------------------------------------------------
// ppt_div
// pipelined restoring divider, num/den as a channel fraction, saturated
// ----------------------------------------------------------------------------
module ppt_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ppt_pkg::NUM_W-1:0]  num,
  input  logic [ppt_pkg::DEN_W-1:0]  den,
  output logic [ppt_pkg::CH_W-1:0]   q
);

  logic [ppt_pkg::DEN_W-1:0]   rem  [ppt_pkg::DIV_LAT];
  logic [ppt_pkg::DEN_W-1:0]   dens [ppt_pkg::DIV_LAT];
  logic [ppt_pkg::CH_FRAC-1:0] qs   [ppt_pkg::DIV_LAT];
  logic                        big  [ppt_pkg::DIV_LAT];
  logic [ppt_pkg::DEN_W:0]     sh   [1:ppt_pkg::DIV_LAT-1];

  always_comb begin
    for (int k = 1; k < ppt_pkg::DIV_LAT; k++) sh[k] = {rem[k-1], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= ppt_pkg::DEN_W'(num);
      dens[0] <= den;
      qs[0]   <= '0;
      big[0]  <= ppt_pkg::DEN_W'(num) >= den;
      for (int k = 1; k < ppt_pkg::DIV_LAT; k++) begin
        dens[k] <= dens[k-1];
        big[k]  <= big[k-1];
        if (sh[k] >= {1'b0, dens[k-1]}) begin
          rem[k] <= ppt_pkg::DEN_W'(sh[k] - {1'b0, dens[k-1]});
          qs[k]  <= {qs[k-1][ppt_pkg::CH_FRAC-2:0], 1'b1};
        end else begin
          rem[k] <= sh[k][ppt_pkg::DEN_W-1:0];
          qs[k]  <= {qs[k-1][ppt_pkg::CH_FRAC-2:0], 1'b0};
        end
      end
    end
  end

  assign q = big[ppt_pkg::DIV_LAT-1] ? ppt_pkg::CH_ONE
                                      : ppt_pkg::CH_W'(qs[ppt_pkg::DIV_LAT-1]);

endmodule

>>> rtl/ppt_search.sv
// ----------------------------------------------------------------------------
// ppt_search
// largest channel value whose log stays at or below a target, bit by bit
// ----------------------------------------------------------------------------
module ppt_search (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ppt_pkg::TGT_W-1:0]   target,
  output logic [ppt_pkg::SRCH_W-1:0]  y
);

  logic [ppt_pkg::SRCH_W-1:0] y_chain [0:ppt_pkg::SRCH_W];
  logic [ppt_pkg::TGT_W-1:0]  t_chain [0:ppt_pkg::SRCH_W];
  logic [ppt_pkg::TGT_W-1:0]  t0;

  always_ff @(posedge clk) begin
    if (en) t0 <= target;
  end

  assign y_chain[0] = '0;
  assign t_chain[0] = t0;

  for (genvar k = 0; k < ppt_pkg::SRCH_W; k++) begin : g_step
    localparam logic [ppt_pkg::SRCH_W-1:0] MASK =
      ppt_pkg::SRCH_W'(1) << (ppt_pkg::SRCH_W - 1 - k);
    logic [ppt_pkg::SRCH_W-1:0] trial;
    logic [ppt_pkg::LG_W-1:0]   lgt;
    logic [ppt_pkg::SRCH_W-1:0] tr_d [ppt_pkg::LG_LAT];
    logic [ppt_pkg::TGT_W-1:0]  tg_d [ppt_pkg::LG_LAT];
    logic [ppt_pkg::SRCH_W-1:0] y_q;
    logic [ppt_pkg::TGT_W-1:0]  t_q;

    assign trial = y_chain[k] | MASK;

    ppt_lg u_lg (
      .clk (clk),
      .en  (en),
      .x   (32'(trial)),
      .r   (lgt)
    );

    always_ff @(posedge clk) begin
      if (en) begin
        tr_d[0] <= trial;
        tg_d[0] <= t_chain[k];
        for (int j = 1; j < ppt_pkg::LG_LAT; j++) begin
          tr_d[j] <= tr_d[j-1];
          tg_d[j] <= tg_d[j-1];
        end
        // keep the trial bit only if its log is within the target
        if (lgt <= ppt_pkg::LG_W'(tg_d[ppt_pkg::LG_LAT-1])) begin
          y_q <= tr_d[ppt_pkg::LG_LAT-1];
        end else begin
          y_q <= tr_d[ppt_pkg::LG_LAT-1] & ~MASK;
        end
        t_q <= tg_d[ppt_pkg::LG_LAT-1];
      end
    end

    assign y_chain[k+1] = y_q;
    assign t_chain[k+1] = t_q;
  end

  assign y = y_chain[ppt_pkg::SRCH_W];

endmodule

>>> rtl/ppt_lane.sv
// ----------------------------------------------------------------------------
// ppt_lane
// point transform of one color channel
// ----------------------------------------------------------------------------
module ppt_lane (
  input  logic                      clk,
  input  logic                      en,
  input  ppt_pkg::lane_cfg_t        cfg,
  input  logic [1:0]                op,
  input  logic [ppt_pkg::CH_W-1:0]  v,
  output logic [ppt_pkg::CH_W-1:0]  res
);

  localparam logic signed [29:0] LP_OFS  = 30'(ppt_pkg::CH_FRAC << ppt_pkg::LG_FRAC);
  localparam logic signed [47:0] TGT_OFS = 48'(ppt_pkg::CH_FRAC << ppt_pkg::LG_FRAC);
  localparam int DQ_LAT = ppt_pkg::SRCH_LAT - ppt_pkg::DIV_LAT;

  // input stage
  logic [1:0]               r0_op;
  logic [ppt_pkg::CH_W-1:0] r0_v;
  logic [31:0]              r0_mv;

  always_ff @(posedge clk) begin
    if (en) begin
      r0_op <= op;
      r0_v  <= v;
      r0_mv <= cfg.meff * v;
    end
  end

  // log of m*v
  logic [ppt_pkg::LG_W-1:0] lgv;
  logic [1:0]               op_d [ppt_pkg::LG_LAT];
  logic [ppt_pkg::CH_W-1:0] v_d  [ppt_pkg::LG_LAT];

  ppt_lg u_lg (
    .clk (clk),
    .en  (en),
    .x   (r0_mv),
    .r   (lgv)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      op_d[0] <= r0_op;
      v_d[0]  <= r0_v;
      for (int j = 1; j < ppt_pkg::LG_LAT; j++) begin
        op_d[j] <= op_d[j-1];
        v_d[j]  <= v_d[j-1];
      end
    end
  end

  // log offset, gain and exponent products
  logic signed [29:0]        d;
  logic [1:0]                r2_op;
  logic [ppt_pkg::CH_W-1:0]  r2_v;
  logic                      r2_dpos;
  logic [ppt_pkg::NUM_W-1:0] r2_num;
  logic signed [46:0]        r2_tprod;

  assign d = $signed({1'b0, lgv}) - LP_OFS;

  always_ff @(posedge clk) begin
    if (en) begin
      r2_op    <= op_d[ppt_pkg::LG_LAT-1];
      r2_v     <= v_d[ppt_pkg::LG_LAT-1];
      r2_dpos  <= !d[29] && (d != 30'sd0);
      r2_num   <= cfg.log_gain * d[28:0];
      r2_tprod <= $signed({1'b0, cfg.gamma_exp}) * d;
    end
  end

  // exponent, case decode and unit operands
  logic signed [46:0]        tq;
  logic signed [47:0]        e;
  logic signed [47:0]        tgt;
  logic [1:0]                sel_c;
  logic [ppt_pkg::CH_W-1:0]  fix_c;
  logic [ppt_pkg::NUM_W-1:0] num_c;
  logic [ppt_pkg::DEN_W-1:0] den_c;

  always_comb begin
    // divide by 4096 rounding toward zero
    if (r2_tprod[46]) tq = (r2_tprod + 47'sd4095) >>> 12;
    else              tq = r2_tprod >>> 12;
    e     = 48'(tq) + 48'(cfg.egc);
    tgt   = e + TGT_OFS;
    sel_c = ppt_pkg::SEL_FIX;
    fix_c = '0;
    num_c = r2_num;
    den_c = cfg.den_log;
    case (r2_op)
      ppt_pkg::OP_NEG: begin
        fix_c = (r2_v > ppt_pkg::CH_ONE) ? '0 : ppt_pkg::CH_ONE - r2_v;
      end
      ppt_pkg::OP_LOG: begin
        if (r2_v != '0 && cfg.log_gain != '0 && cfg.lg_ok && r2_dpos) begin
          sel_c = ppt_pkg::SEL_DIV;
        end
      end
      ppt_pkg::OP_POW: begin
        num_c = ppt_pkg::NUM_W'(cfg.gamma_gain);
        den_c = ppt_pkg::DEN_W'(cfg.den_g);
        if (cfg.gamma_gain == '0) begin
          fix_c = '0;
        end else if (cfg.gamma_exp == '0) begin
          sel_c = ppt_pkg::SEL_DIV;
        end else if (r2_v == '0) begin
          fix_c = '0;
        end else if (!e[47]) begin
          fix_c = ppt_pkg::CH_ONE;
        end else if (tgt[47]) begin
          fix_c = '0;
        end else begin
          sel_c = ppt_pkg::SEL_SRCH;
        end
      end
      default: begin
        fix_c = (r2_v > ppt_pkg::CH_ONE) ? ppt_pkg::CH_ONE : r2_v;
      end
    endcase
  end

  logic [1:0]                r3_sel;
  logic [ppt_pkg::CH_W-1:0]  r3_fix;
  logic [ppt_pkg::NUM_W-1:0] r3_num;
  logic [ppt_pkg::DEN_W-1:0] r3_den;
  logic [ppt_pkg::TGT_W-1:0] r3_tgt;

  always_ff @(posedge clk) begin
    if (en) begin
      r3_sel <= sel_c;
      r3_fix <= fix_c;
      r3_num <= num_c;
      r3_den <= den_c;
      r3_tgt <= tgt[ppt_pkg::TGT_W-1:0];
    end
  end

  // arithmetic units
  logic [ppt_pkg::CH_W-1:0]   div_q;
  logic [ppt_pkg::SRCH_W-1:0] srch_y;

  ppt_div u_div (
    .clk (clk),
    .en  (en),
    .num (r3_num),
    .den (r3_den),
    .q   (div_q)
  );

  ppt_search u_srch (
    .clk    (clk),
    .en     (en),
    .target (r3_tgt),
    .y      (srch_y)
  );

  // align decoded case and divider result with the search
  logic [1:0]               sel_d [ppt_pkg::SRCH_LAT];
  logic [ppt_pkg::CH_W-1:0] fix_d [ppt_pkg::SRCH_LAT];
  logic [ppt_pkg::CH_W-1:0] dq_d  [DQ_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sel_d[0] <= r3_sel;
      fix_d[0] <= r3_fix;
      for (int j = 1; j < ppt_pkg::SRCH_LAT; j++) begin
        sel_d[j] <= sel_d[j-1];
        fix_d[j] <= fix_d[j-1];
      end
      dq_d[0] <= div_q;
      for (int j = 1; j < DQ_LAT; j++) dq_d[j] <= dq_d[j-1];
      case (sel_d[ppt_pkg::SRCH_LAT-1])
        ppt_pkg::SEL_DIV:  res <= dq_d[DQ_LAT-1];
        ppt_pkg::SEL_SRCH: res <= ppt_pkg::CH_W'(srch_y);
        default:           res <= fix_d[ppt_pkg::SRCH_LAT-1];
      endcase
    end
  end

endmodule

>>> rtl/pixel_point_transform_core.sv
// ----------------------------------------------------------------------------
// pixel_point_transform_core
// negative, log, power and clamp transforms on one rgb pixel per transaction
// ----------------------------------------------------------------------------
// one pixel per clock sustained while the output accepts results; the
// time from input transaction to result is set by the power path: a log2
// of m*v (25 stages), then fifteen result bits each found by its own 25 stage
// log2 of the trial value plus a compare stage. three identical lanes handle
// red, green and blue; their results are merged into one output word behind
// an output register and a skid stage, so input keeps flowing while one
// result waits. the settings-derived logs (of m, gamma gain and log radix)
// run in free pipelines and settle after a register write, before any pixel
// needs them. registers must only be written with no pixel in flight. there is
// no clearing pass after reset.
module pixel_point_transform_core (
  input  logic        clk,
  input  logic        rst,
  // slave side: tdata = red_in[15:0], green_in[31:16], blue_in[47:32]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  // tuser = opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  // master side: tdata = red_out[15:0], green_out[31:16], blue_out[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int W = ppt_pkg::CH_W;

  // settings registers
  logic [15:0] max_intensity;
  logic [15:0] log_gain;
  logic [15:0] log_radix;
  logic [15:0] gamma_gain;
  logic [15:0] gamma_exponent;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_intensity  <= 16'd255;
      log_gain       <= 16'd0;
      log_radix      <= 16'd8192;
      gamma_gain     <= 16'd0;
      gamma_exponent <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppt_pkg::CFG_MAX_INTENSITY:  max_intensity  <= cfg_data;
        ppt_pkg::CFG_LOG_GAIN:       log_gain       <= cfg_data;
        ppt_pkg::CFG_LOG_RADIX:      log_radix      <= cfg_data;
        ppt_pkg::CFG_GAMMA_GAIN:     gamma_gain     <= cfg_data;
        ppt_pkg::CFG_GAMMA_EXPONENT: gamma_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero maximum behaves as one
  logic [15:0] meff;
  assign meff = (max_intensity == 16'd0) ? 16'd1 : max_intensity;

  // free-running logs of the settings
  logic [ppt_pkg::LG_W-1:0] lg_m;
  logic [ppt_pkg::LG_W-1:0] lg_gg;
  logic [ppt_pkg::LG_W-1:0] lg_rad;

  ppt_lg u_lg_m (
    .clk (clk), .en (1'b1), .x (32'(meff)), .r (lg_m)
  );
  ppt_lg u_lg_gg (
    .clk (clk), .en (1'b1), .x (32'(gamma_gain)), .r (lg_gg)
  );
  ppt_lg u_lg_rad (
    .clk (clk), .en (1'b1), .x (32'(log_radix)), .r (lg_rad)
  );

  // log base offset, power exponent offset and divisors
  localparam logic signed [31:0] RAD_OFS  = 32'(12 << ppt_pkg::LG_FRAC);
  localparam logic signed [31:0] GAIN_OFS = 32'(13 << ppt_pkg::LG_FRAC);

  logic signed [31:0]        lb;
  logic                      lg_ok;
  logic signed [31:0]        egc;
  logic [ppt_pkg::DEN_W-1:0] den_log;
  logic [28:0]               den_g;

  assign lb = $signed(32'(lg_rad)) - RAD_OFS;

  always_ff @(posedge clk) begin
    lg_ok   <= !lb[31] && (lb != 32'sd0);
    egc     <= $signed(32'(lg_gg)) - GAIN_OFS - $signed(32'(lg_m));
    den_log <= (ppt_pkg::DEN_W'(lb[25:0]) * ppt_pkg::DEN_W'(meff)) << 8;
    den_g   <= 29'(meff) << 13;
  end

  ppt_pkg::lane_cfg_t lane_cfg;
  assign lane_cfg = '{meff:       meff,
                      log_gain:   log_gain,
                      gamma_gain: gamma_gain,
                      gamma_exp:  gamma_exponent,
                      lg_ok:      lg_ok,
                      egc:        egc,
                      den_log:    den_log,
                      den_g:      den_g};

  // pipeline advances whenever the skid stage is free
  logic skid_valid;
  logic en;
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  // transaction valid marks, one per lane stage
  logic vld [ppt_pkg::LANE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < ppt_pkg::LANE_LAT; j++) vld[j] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int j = 1; j < ppt_pkg::LANE_LAT; j++) vld[j] <= vld[j-1];
    end
  end

  // one lane per color channel
  logic [W*ppt_pkg::LANES-1:0] lane_res;

  for (genvar l = 0; l < ppt_pkg::LANES; l++) begin : g_lane
    ppt_lane u_lane (
      .clk (clk),
      .en  (en),
      .cfg (lane_cfg),
      .op  (s_axis_tuser),
      .v   (s_axis_tdata[W*l +: W]),
      .res (lane_res[W*l +: W])
    );
  end

  // merge: output register with skid stage
  logic                        out_valid;
  logic [W*ppt_pkg::LANES-1:0] out_data;
  logic [W*ppt_pkg::LANES-1:0] skid_data;
  logic                        p_v;

  assign p_v = vld[ppt_pkg::LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= p_v;
      end
    end else if (p_v) begin
      // en holds here, since skid is empty whenever output is stalled first
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_data <= skid_valid ? skid_data : lane_res;
    end else if (p_v && !skid_valid) begin
      skid_data <= lane_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // a parked result always has one ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid holds a result with the output register empty");

  // a stalled output with a parked result keeps input closed
  a_stall_closes_input: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_axis_tready) |=> (skid_valid && !s_axis_tready))
    else $error("parked result dropped or input opened under stall");

  // every channel result is saturated to full scale
  a_saturated: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= ppt_pkg::CH_ONE &&
                       m_axis_tdata[31:16] <= ppt_pkg::CH_ONE &&
                       m_axis_tdata[47:32] <= ppt_pkg::CH_ONE))
    else $error("channel result above full scale");

endmodule
